// ----- hdl/packet_loss_reorder_duplicate_emulator_assert.svh -----
// Assertion macros for the impairment emulator.
`ifndef PACKET_LOSS_REORDER_DUPLICATE_EMULATOR_ASSERT_SVH
`define PACKET_LOSS_REORDER_DUPLICATE_EMULATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define PLRD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("plrd: same-cycle check failed");
`define PLRD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("plrd: next-cycle check failed");
`else
`define PLRD_ASSERT_IMP(label, clk, rst, ante, cons)
`define PLRD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/plrd_pkg.sv -----
package plrd_pkg;

   localparam int HOLD_DEPTH = 16;
   localparam int HOLD_AW    = $clog2(HOLD_DEPTH);
   localparam int CNT_W      = $clog2(HOLD_DEPTH + 1);

   localparam int HANDLE_W = 32;
   localparam int LENGTH_W = 12;
   localparam int ROLL_W   = 16;
   localparam int RATE_W   = 17;
   localparam int BURST_W  = 16;
   localparam int DEPTH_W  = 5;
   localparam int TOTAL_W  = 32;

   localparam logic [LENGTH_W-1:0] MAX_PACKET_LENGTH = LENGTH_W'(2048);

   typedef enum logic [1:0] {
      FUNC_SEND  = 2'd0,
      FUNC_FLUSH = 2'd1,
      FUNC_STATS = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      REG_LOSS_RATE      = 3'd0,
      REG_BURST_LENGTH   = 3'd1,
      REG_REORDER_RATE   = 3'd2,
      REG_REORDER_DEPTH  = 3'd3,
      REG_DUPLICATE_RATE = 3'd4
   } reg_index_type;

   typedef enum logic {
      KIND_PACKET = 1'b0,
      KIND_STATS  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DUP,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [LENGTH_W-1:0] length;
   } hold_entry_type;

   typedef struct packed {
      logic                 en;
      logic [HOLD_AW-1:0]   addr;
      hold_entry_type       data;
   } hold_wr_type;

endpackage

// ----- hdl/plrd_hold_ram.sv -----
module plrd_hold_ram
   import plrd_pkg::*;
(
   input  logic                clock,
   input  hold_wr_type         wr,
   input  logic [HOLD_AW-1:0]  rd_addr,
   output hold_entry_type      rd_data_ff
);

   hold_entry_type mem [HOLD_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ----- hdl/packet_loss_reorder_duplicate_emulator.sv -----
// A forwarded packet or statistics report appears in the cycle after its beat is taken.
// Send, stats or empty flush let next beat in while output is free; duplicates stall it.
// A hold release (newest first) or flush (oldest first) takes no input while it reads each
// held packet through ST_READ and ST_EMIT, as the hold store read is registered.
// Reset (synchronous, active high) clears counters, burst, hold count, release state,
// output valid and configuration (depth to 1); output data and hold store are not cleared.
`include "packet_loss_reorder_duplicate_emulator_assert.svh"

module packet_loss_reorder_duplicate_emulator
   import plrd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,

   input  logic          req_tvalid,
   output logic          req_tready,
   // packet_handle, packet_length, loss_roll, reorder_roll, duplicate_roll, zero pad
   input  logic [95:0]   req_tdata,
   // func
   input  logic [1:0]    req_tuser,

   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // packet_handle_out, packet_length_out, offered_count, dropped_count,
   // reordered_count, duplicated_count, zero pad
   output logic [175:0]  rsp_tdata,
   // result_kind, is_duplicate, from_hold
   output logic [2:0]    rsp_tuser,
   output logic          rsp_tlast,

   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [16:0]   csr_wdata
);

   // configuration
   logic [RATE_W-1:0]   loss_rate_ff;
   logic [BURST_W-1:0]  burst_length_ff;
   logic [RATE_W-1:0]   reorder_rate_ff;
   logic [DEPTH_W-1:0]  reorder_depth_ff;
   logic [RATE_W-1:0]   duplicate_rate_ff;

   // control state
   state_type           state_ff, state_in;
   logic [BURST_W-1:0]  burst_left_ff, burst_left_in;
   logic [CNT_W-1:0]    held_count_ff, held_count_in;
   logic [HOLD_AW-1:0]  rel_idx_ff, rel_idx_in;
   logic [HOLD_AW-1:0]  rel_end_ff, rel_end_in;
   logic                rel_down_ff, rel_down_in;
   logic [TOTAL_W-1:0]  offered_ff, offered_in;
   logic [TOTAL_W-1:0]  dropped_ff, dropped_in;
   logic [TOTAL_W-1:0]  reordered_ff, reordered_in;
   logic [TOTAL_W-1:0]  duplicated_ff, duplicated_in;

   // output register
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   kind_type            out_kind_ff, out_kind_in;
   logic [HANDLE_W-1:0] out_handle_ff, out_handle_in;
   logic [LENGTH_W-1:0] out_length_ff, out_length_in;
   logic                out_dup_ff, out_dup_in;
   logic                out_hold_ff, out_hold_in;
   logic                out_last_ff, out_last_in;
   logic [TOTAL_W-1:0]  out_offered_ff, out_offered_in;
   logic [TOTAL_W-1:0]  out_dropped_ff, out_dropped_in;
   logic [TOTAL_W-1:0]  out_reordered_ff, out_reordered_in;
   logic [TOTAL_W-1:0]  out_duplicated_ff, out_duplicated_in;
   logic                out_load;

   // input beat fields
   logic [1:0]          in_func;
   logic [HANDLE_W-1:0] in_handle;
   logic [LENGTH_W-1:0] in_length_raw;
   logic [LENGTH_W-1:0] in_length;
   logic [ROLL_W-1:0]   in_loss_roll;
   logic [ROLL_W-1:0]   in_reorder_roll;
   logic [ROLL_W-1:0]   in_dup_roll;

   // decisions
   logic                out_free;
   logic                accept;
   logic                is_send;
   logic                drop;
   logic                hold;
   logic                fwd;
   logic                dup_hit;
   logic                loss_hit;
   logic                reorder_hit;
   logic                room;
   logic [CNT_W-1:0]    held_new;
   logic [DEPTH_W-1:0]  depth_eff;
   logic                release_rev;
   logic                flush_go;
   logic                rel_last;
   logic                in_release;

   hold_wr_type         hold_wr;
   hold_entry_type      hold_rd_ff;

   assign in_func         = req_tuser;
   assign in_handle       = req_tdata[31:0];
   assign in_length_raw   = req_tdata[43:32];
   assign in_loss_roll    = req_tdata[59:44];
   assign in_reorder_roll = req_tdata[75:60];
   assign in_dup_roll     = req_tdata[91:76];

   assign in_length = (in_length_raw > MAX_PACKET_LENGTH) ? MAX_PACKET_LENGTH : in_length_raw;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign loss_hit    = {1'b0, in_loss_roll} < loss_rate_ff;
   assign reorder_hit = {1'b0, in_reorder_roll} < reorder_rate_ff;
   assign dup_hit     = {1'b0, in_dup_roll} < duplicate_rate_ff;

   assign is_send = accept && (in_func == FUNC_SEND);
   assign drop    = is_send && ((burst_left_ff != '0) || loss_hit);
   assign hold    = is_send && !drop && reorder_hit;
   assign fwd     = is_send && !drop && !reorder_hit;

   assign depth_eff = (reorder_depth_ff == '0) ? DEPTH_W'(1) :
                      (reorder_depth_ff > DEPTH_W'(HOLD_DEPTH)) ? DEPTH_W'(HOLD_DEPTH) :
                      reorder_depth_ff;
   assign room        = held_count_ff < CNT_W'(HOLD_DEPTH);
   assign held_new    = held_count_ff + CNT_W'(room);
   assign release_rev = hold && (DEPTH_W'(held_new) >= depth_eff);
   assign flush_go    = accept && (in_func == FUNC_FLUSH) && (held_count_ff != '0);
   assign rel_last    = rel_idx_ff == rel_end_ff;
   assign in_release  = (state_ff == ST_READ) || (state_ff == ST_EMIT);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         loss_rate_ff      <= '0;
         burst_length_ff   <= '0;
         reorder_rate_ff   <= '0;
         reorder_depth_ff  <= DEPTH_W'(1);
         duplicate_rate_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LOSS_RATE:      loss_rate_ff      <= csr_wdata[RATE_W-1:0];
            REG_BURST_LENGTH:   burst_length_ff   <= csr_wdata[BURST_W-1:0];
            REG_REORDER_RATE:   reorder_rate_ff   <= csr_wdata[RATE_W-1:0];
            REG_REORDER_DEPTH:  reorder_depth_ff  <= csr_wdata[DEPTH_W-1:0];
            REG_DUPLICATE_RATE: duplicate_rate_ff <= csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (fwd && dup_hit) begin
               state_in = ST_DUP;
            end else if (release_rev || flush_go) begin
               state_in = ST_READ;
            end
         end
         ST_DUP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = rel_last ? ST_IDLE : ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      burst_left_in = burst_left_ff;
      held_count_in = held_count_ff;
      rel_idx_in    = rel_idx_ff;
      rel_end_in    = rel_end_ff;
      rel_down_in   = rel_down_ff;
      offered_in    = offered_ff + TOTAL_W'(is_send);
      dropped_in    = dropped_ff + TOTAL_W'(drop);
      reordered_in  = reordered_ff + TOTAL_W'(hold);
      duplicated_in = duplicated_ff + TOTAL_W'(fwd && dup_hit);

      hold_wr.en          = hold && room;
      hold_wr.addr        = held_count_ff[HOLD_AW-1:0];
      hold_wr.data.handle = in_handle;
      hold_wr.data.length = in_length;

      out_load          = 1'b0;
      out_kind_in       = out_kind_ff;
      out_handle_in     = out_handle_ff;
      out_length_in     = out_length_ff;
      out_dup_in        = out_dup_ff;
      out_hold_in       = out_hold_ff;
      out_last_in       = out_last_ff;
      out_offered_in    = out_offered_ff;
      out_dropped_in    = out_dropped_ff;
      out_reordered_in  = out_reordered_ff;
      out_duplicated_in = out_duplicated_ff;

      if (drop) begin
         if (burst_left_ff != '0) begin
            burst_left_in = burst_left_ff - BURST_W'(1);
         end else if (burst_length_ff > BURST_W'(1)) begin
            burst_left_in = burst_length_ff - BURST_W'(1);
         end
      end

      if (hold) begin
         held_count_in = release_rev ? '0 : held_new;
      end
      if (release_rev) begin
         rel_idx_in  = HOLD_AW'(held_new - CNT_W'(1));
         rel_end_in  = '0;
         rel_down_in = 1'b1;
      end
      if (flush_go) begin
         held_count_in = '0;
         rel_idx_in    = '0;
         rel_end_in    = HOLD_AW'(held_count_ff - CNT_W'(1));
         rel_down_in   = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (in_func == FUNC_STATS)) begin
               out_load          = 1'b1;
               out_kind_in       = KIND_STATS;
               out_handle_in     = '0;
               out_length_in     = '0;
               out_dup_in        = 1'b0;
               out_hold_in       = 1'b0;
               out_last_in       = 1'b1;
               out_offered_in    = offered_ff;
               out_dropped_in    = dropped_ff;
               out_reordered_in  = reordered_ff;
               out_duplicated_in = duplicated_ff;
            end else if (fwd) begin
               out_load          = 1'b1;
               out_kind_in       = KIND_PACKET;
               out_handle_in     = in_handle;
               out_length_in     = in_length;
               out_dup_in        = 1'b0;
               out_hold_in       = 1'b0;
               out_last_in       = !dup_hit;
               out_offered_in    = '0;
               out_dropped_in    = '0;
               out_reordered_in  = '0;
               out_duplicated_in = '0;
            end
         end
         ST_DUP: begin
            // second copy: handle and length still sit in the output register
            if (out_free) begin
               out_load    = 1'b1;
               out_dup_in  = 1'b1;
               out_last_in = 1'b1;
            end
         end
         ST_READ: ;
         ST_EMIT: begin
            if (out_free) begin
               out_load          = 1'b1;
               out_kind_in       = KIND_PACKET;
               out_handle_in     = hold_rd_ff.handle;
               out_length_in     = hold_rd_ff.length;
               out_dup_in        = 1'b0;
               out_hold_in       = 1'b1;
               out_last_in       = rel_last;
               out_offered_in    = '0;
               out_dropped_in    = '0;
               out_reordered_in  = '0;
               out_duplicated_in = '0;
               if (!rel_last) begin
                  rel_idx_in = rel_down_ff ? rel_idx_ff - HOLD_AW'(1)
                                           : rel_idx_ff + HOLD_AW'(1);
               end
            end
         end
         default: ;
      endcase

      rsp_tvalid_in = out_load ? 1'b1 : (rsp_tvalid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         burst_left_ff <= '0;
         held_count_ff <= '0;
         rel_idx_ff    <= '0;
         rel_end_ff    <= '0;
         rel_down_ff   <= 1'b0;
         offered_ff    <= '0;
         dropped_ff    <= '0;
         reordered_ff  <= '0;
         duplicated_ff <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         burst_left_ff <= burst_left_in;
         held_count_ff <= held_count_in;
         rel_idx_ff    <= rel_idx_in;
         rel_end_ff    <= rel_end_in;
         rel_down_ff   <= rel_down_in;
         offered_ff    <= offered_in;
         dropped_ff    <= dropped_in;
         reordered_ff  <= reordered_in;
         duplicated_ff <= duplicated_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff       <= out_kind_in;
      out_handle_ff     <= out_handle_in;
      out_length_ff     <= out_length_in;
      out_dup_ff        <= out_dup_in;
      out_hold_ff       <= out_hold_in;
      out_last_ff       <= out_last_in;
      out_offered_ff    <= out_offered_in;
      out_dropped_ff    <= out_dropped_in;
      out_reordered_ff  <= out_reordered_in;
      out_duplicated_ff <= out_duplicated_in;
   end

   plrd_hold_ram u_hold_ram (
      .clock      (clock),
      .wr         (hold_wr),
      .rd_addr    (rel_idx_ff),
      .rd_data_ff (hold_rd_ff)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_hold_ff, out_dup_ff, out_kind_ff};
   assign rsp_tdata  = {4'b0, out_duplicated_ff, out_reordered_ff, out_dropped_ff,
                        out_offered_ff, out_length_ff, out_handle_ff};

   `PLRD_ASSERT_IMP(a_release_empty, clock, reset, in_release, held_count_ff == '0)
   `PLRD_ASSERT_IMP(a_dup_pending, clock, reset, state_ff == ST_DUP, rsp_tvalid_ff && !out_dup_ff)
   `PLRD_ASSERT_NXT(a_flush_start, clock, reset, flush_go, state_ff == ST_READ && rel_idx_ff == '0)
   `PLRD_ASSERT_IMP(a_held_bound, clock, reset, state_ff == ST_IDLE, held_count_ff < CNT_W'(HOLD_DEPTH))

endmodule
